### src/value_noise_2d_macros.svh
// ---------------------------------------------------------------------------
// value_noise_2d assertion macros
// Shared property shorthands for the noise block's checkers.
// ---------------------------------------------------------------------------
`ifndef VALUE_NOISE_2D_MACROS_SVH
`define VALUE_NOISE_2D_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define VN2D_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define VN2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/vn2d_pkg.sv
// ---------------------------------------------------------------------------
// vn2d_pkg
// Types and constants shared by the 2D value noise pipeline.
// ---------------------------------------------------------------------------
package vn2d_pkg;

	// Default number of fraction bits in the input position
	localparam int FRAC_BITS_DEF = 16;

	// Register stages from input register to output register
	localparam int NUM_STAGES = 11;

	// Per-stage load enables
	typedef logic [NUM_STAGES:1] stage_en_t;

	// Q0.16 smoothed fraction, Q2.16 corner / result
	typedef logic [15:0]        frac_t;
	typedef logic signed [17:0] corner_t;

	// Lattice hash constants
	localparam logic [31:0] LAT_Y_STEP = 32'd57;
	localparam int          HASH_SHIFT = 13;
	localparam logic [31:0] HASH_MUL_A = 32'd15731;
	localparam logic [31:0] HASH_ADD_B = 32'd789221;
	localparam logic [31:0] HASH_ADD_C = 32'd1376312589;
	localparam logic [31:0] HASH_MASK  = 32'h7fff_ffff;

	// Corner order and their offsets from the base hash index (dx + 57*dy)
	localparam int CORNER_00 = 0;
	localparam int CORNER_10 = 1;
	localparam int CORNER_01 = 2;
	localparam int CORNER_11 = 3;
	localparam int NUM_CORNERS = 4;
	localparam logic [31:0] CORNER_OFF [NUM_CORNERS] = '{32'd0, 32'd1, 32'd57, 32'd58};

	// Fixed-point constants
	localparam corner_t     ONE_Q16  = 18'sd65536;
	localparam logic [17:0] THREE_Q16 = 18'd196608;

	// Legal result range
	localparam corner_t NOISE_MIN = -18'sd65535;
	localparam corner_t NOISE_MAX = 18'sd65536;

endpackage

### src/vn2d_pos_if.sv
// ---------------------------------------------------------------------------
// vn2d_pos_if
// Valid/ready channel carrying one 2D position item.
// ---------------------------------------------------------------------------
interface vn2d_pos_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;

	modport source (output valid, output pos_x, output pos_y, input ready);
	modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface

### src/vn2d_noise_if.sv
// ---------------------------------------------------------------------------
// vn2d_noise_if
// Valid/ready channel carrying one noise result item.
// ---------------------------------------------------------------------------
interface vn2d_noise_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] noise_value;

	modport source (output valid, output noise_value, input ready);
	modport sink (input valid, input noise_value, output ready);
endinterface

### src/vn2d_smooth.sv
// ---------------------------------------------------------------------------
// vn2d_smooth
// Smoothstep 3f^2 - 2f^3 of a Q0.16 fraction over stages 2 to 4.
// ---------------------------------------------------------------------------
module vn2d_smooth (
	input  logic                  clk,
	input  vn2d_pkg::stage_en_t   en,
	input  vn2d_pkg::frac_t       frac,
	output vn2d_pkg::frac_t       smooth
);

	logic [15:0] f_s2;
	logic [15:0] f2_s3;
	logic [17:0] t_s3;
	logic [15:0] s_s4;
	logic [31:0] sq;
	logic [17:0] t;
	logic [33:0] prod;

	// f^2 and (3 - 2f), both Q16
	assign sq = f_s2 * f_s2;
	assign t  = vn2d_pkg::THREE_Q16 - {1'b0, f_s2, 1'b0};

	// f^2 * (3 - 2f), truncated back to Q0.16
	assign prod = f2_s3 * t_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			f_s2 <= frac;
		end
		if (en[3]) begin
			f2_s3 <= sq[31:16];
			t_s3  <= t;
		end
		if (en[4]) begin
			s_s4 <= prod[31:16];
		end
	end

	assign smooth = s_s4;

endmodule

### src/vn2d_hash.sv
// ---------------------------------------------------------------------------
// vn2d_hash
// One corner lane: 32-bit integer lattice hash mapped to a Q2.16 value.
// ---------------------------------------------------------------------------
module vn2d_hash (
	input  logic                  clk,
	input  vn2d_pkg::stage_en_t   en,
	input  logic [31:0]           n,
	output vn2d_pkg::corner_t     corner
);

	logic [31:0] n_s3;
	logic [31:0] sq_s4;
	logic [31:0] n_s4;
	logic [31:0] p_s5;
	logic [31:0] n_s5;
	logic [31:0] h_s6;
	logic [31:0] sq;
	logic [31:0] p;
	logic [31:0] h;
	logic [31:0] hm;

	// n*n, then n*n*A + B, then n*(...), all wrapping at 32 bits
	assign sq = 32'(n_s3 * n_s3);
	assign p  = 32'(sq_s4 * vn2d_pkg::HASH_MUL_A) + vn2d_pkg::HASH_ADD_B;
	assign h  = 32'(n_s5 * p_s5);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			n_s3 <= n;
		end
		if (en[4]) begin
			sq_s4 <= sq;
			n_s4  <= n_s3;
		end
		if (en[5]) begin
			p_s5 <= p;
			n_s5 <= n_s4;
		end
		if (en[6]) begin
			h_s6 <= h;
		end
	end

	// Final offset and mask, then 1 - h/2^30 in Q2.16
	assign hm     = (h_s6 + vn2d_pkg::HASH_ADD_C) & vn2d_pkg::HASH_MASK;
	assign corner = vn2d_pkg::ONE_Q16 - $signed({1'b0, hm[30:14]});

endmodule

### src/vn2d_blend.sv
// ---------------------------------------------------------------------------
// vn2d_blend
// Bilinear blend of four corners over stages 7 to 11, x first, then y.
// ---------------------------------------------------------------------------
module vn2d_blend (
	input  logic                  clk,
	input  vn2d_pkg::stage_en_t   en,
	input  vn2d_pkg::corner_t     c00,
	input  vn2d_pkg::corner_t     c10,
	input  vn2d_pkg::corner_t     c01,
	input  vn2d_pkg::corner_t     c11,
	input  vn2d_pkg::frac_t       su,
	input  vn2d_pkg::frac_t       sv,
	output vn2d_pkg::corner_t     noise_value
);

	logic signed [17:0] c00_s7, c01_s7;
	logic signed [18:0] d0_s7, d1_s7;
	logic [15:0]        su_s7, sv_s7;
	logic signed [35:0] prod0_s8, prod1_s8;
	logic signed [17:0] c00_s8, c01_s8;
	logic [15:0]        sv_s8;
	logic signed [17:0] r0_s9;
	logic signed [18:0] dr_s9;
	logic [15:0]        sv_s9;
	logic signed [35:0] prod_s10;
	logic signed [17:0] r0_s10;
	logic signed [17:0] noise_s11;

	logic signed [18:0] d0, d1;
	logic signed [35:0] prod0, prod1, prod;
	logic signed [19:0] r0_w, r1_w, r_w;
	logic signed [18:0] dr;

	// Corner differences along x
	assign d0 = $signed({c10[17], c10}) - $signed({c00[17], c00});
	assign d1 = $signed({c11[17], c11}) - $signed({c01[17], c01});

	// Scale by the x weight
	assign prod0 = d0_s7 * $signed({1'b0, su_s7});
	assign prod1 = d1_s7 * $signed({1'b0, su_s7});

	// Add floor of the scaled difference; the blend stays within its endpoints
	assign r0_w = $signed({{2{c00_s8[17]}}, c00_s8}) + prod0_s8[35:16];
	assign r1_w = $signed({{2{c01_s8[17]}}, c01_s8}) + prod1_s8[35:16];
	assign dr   = $signed({r1_w[17], r1_w[17:0]}) - $signed({r0_w[17], r0_w[17:0]});

	// Blend along y
	assign prod = dr_s9 * $signed({1'b0, sv_s9});
	assign r_w  = $signed({{2{r0_s10[17]}}, r0_s10}) + prod_s10[35:16];

	always_ff @(posedge clk) begin
		if (en[7]) begin
			c00_s7 <= c00;
			c01_s7 <= c01;
			d0_s7  <= d0;
			d1_s7  <= d1;
			su_s7  <= su;
			sv_s7  <= sv;
		end
		if (en[8]) begin
			prod0_s8 <= prod0;
			prod1_s8 <= prod1;
			c00_s8   <= c00_s7;
			c01_s8   <= c01_s7;
			sv_s8    <= sv_s7;
		end
		if (en[9]) begin
			r0_s9 <= r0_w[17:0];
			dr_s9 <= dr;
			sv_s9 <= sv_s8;
		end
		if (en[10]) begin
			prod_s10 <= prod;
			r0_s10   <= r0_s9;
		end
		if (en[11]) begin
			noise_s11 <= r_w[17:0];
		end
	end

	assign noise_value = noise_s11;

endmodule

### src/value_noise_2d.sv
// ---------------------------------------------------------------------------
// value_noise_2d
// 2D lattice value noise: Q15.16 position in, Q2.16 noise value out.
// ---------------------------------------------------------------------------
// The block takes one position item per clock while pos.ready is high and
// returns one noise item per position, in order. Throughput is one item per
// cycle when the output is not stalled; the figure is set by the 11-stage
// pipeline (split, lattice index, four parallel hash lanes of three 32-bit
// multiplies each, smoothstep, and a two-level bilinear blend). Every stage
// has its own valid bit and loads when it is empty or its successor moves, so
// bubbles close up and a stalled output holds its item while earlier stages
// keep filling. No state is kept between items.
module value_noise_2d #(
	parameter int FRAC_BITS = vn2d_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	vn2d_pos_if.sink             pos,
	vn2d_noise_if.source         noise
);

	localparam int NS = vn2d_pkg::NUM_STAGES;

	vn2d_pkg::stage_en_t en;
	logic [NS:1]         vld_q;

	logic signed [31:0]  pos_x_s1, pos_y_s1;
	logic [31:0]         cx, cy, base;
	logic [31:0]         base_s2;
	vn2d_pkg::frac_t     frac_x, frac_y;
	vn2d_pkg::frac_t     su, sv;
	vn2d_pkg::frac_t     su_s5, sv_s5, su_s6, sv_s6;
	vn2d_pkg::corner_t   corner [vn2d_pkg::NUM_CORNERS];

	// Stage enables: load when empty or when the next stage moves
	always_comb begin
		en[NS] = !vld_q[NS] || noise.ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k + 1];
		end
	end

	// Advance valid bits where enabled, hold elsewhere
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & {vld_q[NS-1:1], pos.valid}) | (~en & vld_q);
		end
	end

	assign pos.ready   = en[1];
	assign noise.valid = vld_q[NS];

	// Input register
	always_ff @(posedge clk) begin
		if (en[1]) begin
			pos_x_s1 <= pos.pos_x;
			pos_y_s1 <= pos.pos_y;
		end
	end

	// Split into lattice cell (floor) and 16-bit fraction
	assign cx = 32'(pos_x_s1 >>> FRAC_BITS);
	assign cy = 32'(pos_y_s1 >>> FRAC_BITS);

	if (FRAC_BITS >= 16) begin : g_frac_trunc
		assign frac_x = pos_x_s1[FRAC_BITS-1 -: 16];
		assign frac_y = pos_y_s1[FRAC_BITS-1 -: 16];
	end else begin : g_frac_widen
		assign frac_x = {pos_x_s1[FRAC_BITS-1:0], {(16 - FRAC_BITS){1'b0}}};
		assign frac_y = {pos_y_s1[FRAC_BITS-1:0], {(16 - FRAC_BITS){1'b0}}};
	end

	// Base hash index of the lower-left corner
	assign base = cx + 32'(cy * vn2d_pkg::LAT_Y_STEP);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			base_s2 <= base;
		end
	end

	// Smoothed weights along x and y
	vn2d_smooth u_smooth_x (
		.clk    (clk),
		.en     (en),
		.frac   (frac_x),
		.smooth (su)
	);

	vn2d_smooth u_smooth_y (
		.clk    (clk),
		.en     (en),
		.frac   (frac_y),
		.smooth (sv)
	);

	// Carry the weights alongside the hash lanes
	always_ff @(posedge clk) begin
		if (en[5]) begin
			su_s5 <= su;
			sv_s5 <= sv;
		end
		if (en[6]) begin
			su_s6 <= su_s5;
			sv_s6 <= sv_s5;
		end
	end

	// One hash lane per corner; neighbor cells wrap at 32 bits
	for (genvar i = 0; i < vn2d_pkg::NUM_CORNERS; i++) begin : g_corner
		logic [31:0] m;
		logic [31:0] n;

		assign m = base_s2 + vn2d_pkg::CORNER_OFF[i];
		assign n = m ^ (m << vn2d_pkg::HASH_SHIFT);

		vn2d_hash u_hash (
			.clk    (clk),
			.en     (en),
			.n      (n),
			.corner (corner[i])
		);
	end

	// Bilinear blend and output register
	vn2d_blend u_blend (
		.clk         (clk),
		.en          (en),
		.c00         (corner[vn2d_pkg::CORNER_00]),
		.c10         (corner[vn2d_pkg::CORNER_10]),
		.c01         (corner[vn2d_pkg::CORNER_01]),
		.c11         (corner[vn2d_pkg::CORNER_11]),
		.su          (su_s6),
		.sv          (sv_s6),
		.noise_value (noise.noise_value)
	);

endmodule

### src/vn2d_chk.sv
// ---------------------------------------------------------------------------
// vn2d_chk
// Port-level checker for value_noise_2d, attached by bind.
// ---------------------------------------------------------------------------
`include "value_noise_2d_macros.svh"

module vn2d_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [17:0] noise_value
);

	localparam int CNT_W = $clog2(vn2d_pkg::NUM_STAGES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(vn2d_pkg::NUM_STAGES);

	logic             in_acc, out_acc;
	logic [CNT_W-1:0] count_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Track items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_acc && !out_acc) begin
			count_q <= count_q + 1'b1;
		end else if (!in_acc && out_acc) begin
			count_q <= count_q - 1'b1;
		end
	end

	`VN2D_ASSERT_IMP(a_no_invented_item, clk, arst_n, out_valid, count_q != '0, "result item with no input item in flight")
	`VN2D_ASSERT_IMP(a_flight_bound, clk, arst_n, 1'b1, count_q <= CNT_MAX, "more items in flight than pipeline stages")
	`VN2D_ASSERT_IMP(a_value_range, clk, arst_n, out_valid, noise_value >= vn2d_pkg::NOISE_MIN && noise_value <= vn2d_pkg::NOISE_MAX, "noise value out of range")
	`VN2D_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(noise_value), "stalled result item changed")

endmodule

bind value_noise_2d vn2d_chk u_vn2d_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pos.valid),
	.in_ready    (pos.ready),
	.out_valid   (noise.valid),
	.out_ready   (noise.ready),
	.noise_value (noise.noise_value)
);
